FILE: src/gb2312_glyph_address_engine_macros.svh
// assertion macros for the gb2312 glyph address engine
// expects clk and rst_n in the scope of each use
`ifndef GB2312_GLYPH_ADDRESS_ENGINE_MACROS_SVH
`define GB2312_GLYPH_ADDRESS_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define GBGA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbga assertion failed");
`define GBGA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbga assertion failed");
`else
`define GBGA_ASSERT_SAME(lbl, ante, cons)
`define GBGA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/gbga_pkg.sv
// shared types, constants and size tables of the glyph address engine
// no dependencies
package gbga_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int CMP_W       = (COORD_WIDTH + 1 > 11) ? COORD_WIDTH + 1 : 11;
    localparam int POS_W       = 10;
    localparam int ADDR_W      = 24;
    localparam int CNT_W       = 8;
    localparam int IDX_W       = 13;
    localparam int ADV_W       = 6;
    localparam int BASE_W      = 20;
    localparam int FS_W        = 3;
    localparam int SW_W        = 11;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};

    localparam logic [7:0] SYM_LO    = 8'hA1;
    localparam logic [7:0] SYM_HI    = 8'hA9;
    localparam logic [7:0] HANZI_LO  = 8'hB0;
    localparam logic [7:0] HANZI_HI  = 8'hF7;
    localparam logic [7:0] TRAIL_LO  = 8'hA1;
    localparam logic [IDX_W-1:0] ROW_LEN   = IDX_W'(94);
    localparam logic [IDX_W-1:0] HANZI_OFS = IDX_W'(846);

    localparam logic [FS_W-1:0] FONT_SIZE_RESET    = 3'd2;
    localparam logic [SW_W-1:0] SCREEN_WIDTH_RESET = 11'd240;

    localparam logic CFG_FONT_SIZE    = 1'b0;
    localparam logic CFG_SCREEN_WIDTH = 1'b1;

    typedef logic [COORD_WIDTH-1:0] coord_t;

    typedef enum logic [1:0] {
        SZ_12 = 2'd0,
        SZ_16 = 2'd1,
        SZ_24 = 2'd2,
        SZ_32 = 2'd3
    } size_t;

    typedef struct packed {
        logic start;
        logic take_lead;
        logic end_str;
        logic take_trail;
        logic calc;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic op_start;
        logic byte_zero;
        logic lead_pending;
        logic string_ended;
        logic emit;
        logic out_free;
    } status_t;

    function automatic size_t size_sel(input logic [FS_W-1:0] fs);
        size_t s;
        case (fs) inside
            3'd0, 3'd1: s = SZ_12;
            3'd2:       s = SZ_16;
            3'd3:       s = SZ_24;
            default:    s = SZ_32;
        endcase
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] size_bytes(input size_t s);
        logic [CNT_W-1:0] n;
        case (s)
            SZ_12:   n = 8'd24;
            SZ_16:   n = 8'd32;
            SZ_24:   n = 8'd72;
            default: n = 8'd128;
        endcase
        return n;
    endfunction

    function automatic logic [ADV_W-1:0] size_adv(input size_t s);
        logic [ADV_W-1:0] a;
        case (s)
            SZ_12:   a = 6'd12;
            SZ_16:   a = 6'd16;
            SZ_24:   a = 6'd24;
            default: a = 6'd32;
        endcase
        return a;
    endfunction

    function automatic logic [BASE_W-1:0] size_base(input size_t s);
        logic [BASE_W-1:0] b;
        case (s)
            SZ_12:   b = 20'h00000;
            SZ_16:   b = 20'h2C9D0;
            SZ_24:   b = 20'h68190;
            default: b = 20'hEDF00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/gbga_in_if.sv
// input channel of the glyph address engine: valid, ready and text item
// depends on gbga_pkg
interface gbga_in_if
    import gbga_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [7:0]       text_byte;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;

    modport source (output valid, opcode, text_byte, start_x, start_y, input ready);
    modport sink (input valid, opcode, text_byte, start_x, start_y, output ready);
endinterface

FILE: src/gbga_out_if.sv
// output channel of the glyph address engine: valid, ready and glyph item
// depends on gbga_pkg
interface gbga_out_if
    import gbga_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] rom_address;
    logic [CNT_W-1:0]  byte_count;
    logic [POS_W-1:0]  glyph_x;
    logic [POS_W-1:0]  glyph_y;

    modport source (output valid, rom_address, byte_count, glyph_x, glyph_y, input ready);
    modport sink (input valid, rom_address, byte_count, glyph_x, glyph_y, output ready);
endinterface

FILE: src/gbga_ctrl.sv
// controller of the glyph address engine: accepts items, sequences index and address
// depends on gbga_pkg and the assertion macro header
`include "gb2312_glyph_address_engine_macros.svh"

module gbga_ctrl
    import gbga_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_INDEX = 3'b010,
        S_ADDR  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.op_start)
                    begin
                        cmd.start = 1'b1;
                    end
                    else if (!status.string_ended)
                    begin
                        if (!status.lead_pending)
                        begin
                            if (status.byte_zero)
                            begin
                                cmd.end_str = 1'b1;
                            end
                            else
                            begin
                                cmd.take_lead = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.take_trail = 1'b1;
                            state_next     = S_INDEX;
                        end
                    end
                end
            end
            S_INDEX:
            begin
                cmd.calc   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                if (!status.emit)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `GBGA_ASSERT_NEXT(a_index_then_addr, state_reg == S_INDEX, state_reg == S_ADDR)
    `GBGA_ASSERT_SAME(a_load_needs_room, cmd.load_out, status.out_free && status.emit)
    `GBGA_ASSERT_SAME(a_trail_after_lead, cmd.take_trail,
                      status.lead_pending && !status.string_ended && !status.op_start)

endmodule

FILE: src/gbga_dp.sv
// datapath of the glyph address engine: config registers, cursor, index, address, output
// depends on gbga_pkg
module gbga_dp
    import gbga_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               opcode,
    input  logic [7:0]         text_byte,
    input  logic [POS_W-1:0]   start_x,
    input  logic [POS_W-1:0]   start_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  rom_address,
    output logic [CNT_W-1:0]   byte_count,
    output logic [POS_W-1:0]   glyph_x,
    output logic [POS_W-1:0]   glyph_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata
);

    logic [FS_W-1:0]   font_size_reg;
    logic [SW_W-1:0]   screen_width_reg;
    coord_t            cursor_col_reg, cursor_col_next;
    coord_t            cursor_row_reg, cursor_row_next;
    logic [7:0]        held_lead_reg;
    logic              lead_pending_reg, lead_pending_next;
    logic              string_ended_reg, string_ended_next;
    logic [7:0]        trail_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              emit_reg;
    coord_t            gx_reg, gy_reg;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] rom_address_reg;
    logic [CNT_W-1:0]  byte_count_reg;
    logic [POS_W-1:0]  glyph_x_reg, glyph_y_reg;

    size_t                   sel;
    logic [ADV_W-1:0]        adv;
    logic [CMP_W-1:0]        col_sum;
    logic                    wrap;
    logic [COORD_WIDTH:0]    row_sum;
    coord_t                  row_sat;
    coord_t                  col_base;
    logic [COORD_WIDTH:0]    col_adv_sum;
    coord_t                  col_sat;
    logic                    is_sym, is_hz;
    logic [6:0]              lead_row;
    logic [IDX_W-1:0]        idx_calc;
    logic [IDX_W+CNT_W-1:0]  prod;
    logic [ADDR_W-1:0]       addr_calc;
    logic                    cfg_wr;

    // config port
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == CFG_SCREEN_WIDTH) ? PDATA_W'(screen_width_reg)
                                                   : PDATA_W'(font_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg    <= FONT_SIZE_RESET;
            screen_width_reg <= SCREEN_WIDTH_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_FONT_SIZE)
            begin
                font_size_reg <= pwdata[FS_W-1:0];
            end
            else
            begin
                screen_width_reg <= pwdata[SW_W-1:0];
            end
        end
    end

    // size and cursor wrap
    assign sel         = size_sel(font_size_reg);
    assign adv         = size_adv(sel);
    assign col_sum     = CMP_W'(cursor_col_reg) + CMP_W'(adv);
    assign wrap        = col_sum > CMP_W'(screen_width_reg);
    assign row_sum     = (COORD_WIDTH + 1)'(cursor_row_reg) + (COORD_WIDTH + 1)'(adv);
    assign row_sat     = row_sum[COORD_WIDTH] ? COORD_MAX : row_sum[COORD_WIDTH-1:0];
    assign col_base    = wrap ? '0 : cursor_col_reg;
    assign col_adv_sum = (COORD_WIDTH + 1)'(col_base) + (COORD_WIDTH + 1)'(adv);
    assign col_sat     = col_adv_sum[COORD_WIDTH] ? COORD_MAX : col_adv_sum[COORD_WIDTH-1:0];

    // glyph index
    assign is_sym   = (trail_reg >= TRAIL_LO) && (held_lead_reg >= SYM_LO)
                      && (held_lead_reg <= SYM_HI);
    assign is_hz    = (trail_reg >= TRAIL_LO) && (held_lead_reg >= HANZI_LO)
                      && (held_lead_reg <= HANZI_HI);
    assign lead_row = 7'(is_sym ? (held_lead_reg - SYM_LO) : (held_lead_reg - HANZI_LO));
    assign idx_calc = IDX_W'(lead_row) * ROW_LEN + IDX_W'(trail_reg - TRAIL_LO)
                      + (is_hz ? HANZI_OFS : '0);

    // rom address
    assign prod      = (IDX_W + CNT_W)'(idx_reg) * (IDX_W + CNT_W)'(size_bytes(sel));
    assign addr_calc = ADDR_W'(prod) + ADDR_W'(size_base(sel));

    always_comb
    begin
        cursor_col_next   = cursor_col_reg;
        cursor_row_next   = cursor_row_reg;
        lead_pending_next = lead_pending_reg;
        string_ended_next = string_ended_reg;
        if (cmd.start)
        begin
            cursor_col_next   = COORD_WIDTH'(start_x);
            cursor_row_next   = COORD_WIDTH'(start_y);
            lead_pending_next = 1'b0;
            string_ended_next = 1'b0;
        end
        else if (cmd.end_str)
        begin
            string_ended_next = 1'b1;
        end
        else if (cmd.take_lead)
        begin
            lead_pending_next = 1'b1;
        end
        else if (cmd.take_trail)
        begin
            lead_pending_next = 1'b0;
        end
        else if (cmd.calc)
        begin
            if (wrap)
            begin
                cursor_row_next = row_sat;
            end
            cursor_col_next = col_sat;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg   <= '0;
            cursor_row_reg   <= '0;
            held_lead_reg    <= '0;
            lead_pending_reg <= 1'b0;
            string_ended_reg <= 1'b1;
            emit_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cursor_col_reg   <= cursor_col_next;
            cursor_row_reg   <= cursor_row_next;
            lead_pending_reg <= lead_pending_next;
            string_ended_reg <= string_ended_next;
            out_valid_reg    <= out_valid_next;
            if (cmd.start)
            begin
                held_lead_reg <= '0;
            end
            else if (cmd.take_lead)
            begin
                held_lead_reg <= text_byte;
            end
            if (cmd.calc)
            begin
                emit_reg <= is_sym || is_hz;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_trail)
        begin
            trail_reg <= text_byte;
        end
        if (cmd.calc)
        begin
            idx_reg <= idx_calc;
            gx_reg  <= col_base;
            gy_reg  <= wrap ? row_sat : cursor_row_reg;
        end
        if (cmd.load_out)
        begin
            rom_address_reg <= addr_calc;
            byte_count_reg  <= size_bytes(sel);
            glyph_x_reg     <= POS_W'(gx_reg);
            glyph_y_reg     <= POS_W'(gy_reg);
        end
    end

    assign status.op_start     = (opcode == 1'b0);
    assign status.byte_zero    = (text_byte == 8'd0);
    assign status.lead_pending = lead_pending_reg;
    assign status.string_ended = string_ended_reg;
    assign status.emit         = emit_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign rom_address = rom_address_reg;
    assign byte_count  = byte_count_reg;
    assign glyph_x     = glyph_x_reg;
    assign glyph_y     = glyph_y_reg;

endmodule

FILE: src/gb2312_glyph_address_engine.sv
// top level of the gb2312 glyph address engine: controller, datapath, channels, config port
// depends on gbga_pkg, gbga_in_if, gbga_out_if, gbga_ctrl and gbga_dp
//
// channel   dir   carries
// in_ch     in    opcode, text_byte, start_x, start_y
// out_ch    out   rom_address, byte_count, glyph_x, glyph_y
// apb       in    font_size at 0x0, screen_width at 0x4
//
// start, lead, end and ignored bytes are handled in the idle state; a trail byte goes through
// accept, index and cursor wrap, and address multiply before the next item is taken
// the finished glyph waits in an output register; the address cycle stalls only
// while that register still holds an item not taken
// reset: cursor at 0,0, string ended, font_size 2, screen_width 240
module gb2312_glyph_address_engine
    import gbga_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gbga_in_if.sink            in_ch,
    gbga_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    gbga_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gbga_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (in_ch.opcode),
        .text_byte   (in_ch.text_byte),
        .start_x     (in_ch.start_x),
        .start_y     (in_ch.start_y),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .rom_address (out_ch.rom_address),
        .byte_count  (out_ch.byte_count),
        .glyph_x     (out_ch.glyph_x),
        .glyph_y     (out_ch.glyph_y),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata)
    );

endmodule
